// File: hw/rtl/kvt_pkg.sv
package kvt_pkg;

  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned KEY_BITS     = 32;
  localparam int unsigned VALUE_BITS   = 64;
  localparam int unsigned VERSION_BITS = 32;

  localparam int unsigned IDX_W      = $clog2(ENTRIES);
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);
  localparam int unsigned ENTRY_BITS = KEY_BITS + VALUE_BITS + VERSION_BITS;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_DELETE = 2'd3
  } kvt_cmd_e;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_EXISTS   = 3'd1,
    STATUS_MISSING  = 3'd2,
    STATUS_MISMATCH = 3'd3,
    STATUS_FULL     = 3'd4
  } kvt_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } kvt_state_e;

  // Outcome of one pass over the table.
  typedef struct packed {
    logic                    hit;
    logic [IDX_W-1:0]        hit_idx;
    logic [VALUE_BITS-1:0]   hit_value;
    logic [VERSION_BITS-1:0] hit_version;
    logic                    free;
    logic [IDX_W-1:0]        free_idx;
  } scan_res_t;

  // Change to one valid mark.
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } vld_upd_t;

endpackage

// File: hw/rtl/kvt_ram.sv
module kvt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/kvt_scan.sv
module kvt_scan (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [kvt_pkg::KEY_BITS-1:0]     key_i,
  input  kvt_pkg::vld_upd_t                upd_i,
  output logic                             rd_en_o,
  output logic [kvt_pkg::IDX_W-1:0]        rd_addr_o,
  input  logic [kvt_pkg::ENTRY_BITS-1:0]   rd_data_i,
  output logic                             done_o,
  output kvt_pkg::scan_res_t               res_o
);

  logic [kvt_pkg::ENTRIES-1:0] valid_q;
  logic                        busy_q, busy_d;
  logic [kvt_pkg::CNT_W-1:0]   issue_cnt_q, issue_cnt_d;
  logic                        cmp_vld_q, cmp_vld_d;
  logic [kvt_pkg::IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  kvt_pkg::scan_res_t          res_q, res_d;
  logic                        issue_done;
  logic [kvt_pkg::KEY_BITS-1:0] rd_key;

  assign issue_done = (issue_cnt_q == kvt_pkg::CNT_W'(kvt_pkg::ENTRIES));
  assign rd_key     = rd_data_i[kvt_pkg::ENTRY_BITS-1 -: kvt_pkg::KEY_BITS];
  assign rd_en_o    = busy_q && !issue_done;
  assign rd_addr_o  = issue_cnt_q[kvt_pkg::IDX_W-1:0];
  // The last compare lands in res_q at the same edge that ends the pass.
  assign done_o     = busy_q && issue_done;
  assign res_o      = res_q;

  always_comb begin
    busy_d      = busy_q;
    issue_cnt_d = issue_cnt_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    res_d       = res_q;
    if (start_i) begin
      busy_d      = 1'b1;
      issue_cnt_d = '0;
      res_d.hit   = 1'b0;
      res_d.free  = 1'b0;
    end else begin
      if (busy_q) begin
        if (issue_done) begin
          busy_d = 1'b0;
        end else begin
          issue_cnt_d = issue_cnt_q + kvt_pkg::CNT_W'(1);
          cmp_vld_d   = 1'b1;
          cmp_idx_d   = rd_addr_o;
        end
      end
      if (cmp_vld_q) begin
        if (valid_q[cmp_idx_q] && (rd_key == key_i) && !res_q.hit) begin
          res_d.hit         = 1'b1;
          res_d.hit_idx     = cmp_idx_q;
          res_d.hit_value   = rd_data_i[kvt_pkg::VERSION_BITS +: kvt_pkg::VALUE_BITS];
          res_d.hit_version = rd_data_i[kvt_pkg::VERSION_BITS-1:0];
        end
        if (!valid_q[cmp_idx_q] && !res_q.free) begin
          res_d.free     = 1'b1;
          res_d.free_idx = cmp_idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      busy_q      <= 1'b0;
      issue_cnt_q <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      res_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      issue_cnt_q <= issue_cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      res_q       <= res_d;
      if (upd_i.set) begin
        valid_q[upd_i.idx] <= 1'b1;
      end else if (upd_i.clr) begin
        valid_q[upd_i.idx] <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/versioned_key_value_table_unit.sv
// Channel | Direction | Handshake               | Beat contents
// input   | in        | in_valid_i / in_stall_o   | cmd, lookup_key, new_value, new_version,
//         |           |                         | expected_version
// output  | out       | out_valid_o / out_stall_i | status, found, read_value, read_version
//
// Every command runs from acceptance to a loaded result as one pass over the entry memory
// reading one entry per cycle, with each compare trailing its read, then a response state that
// loads the result, writes the entry of a successful create or update, or unmarks a deleted key.
// The single read port of the entry memory is why the pass reads one entry at a time.
// Reset clears all valid marks at once; no clearing pass is needed.
// A finished result waits in the output register while the next command is accepted;
// a stalled output holds the response cycle until the register frees up.
module versioned_key_value_table_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          cmd_i,
  input  logic [kvt_pkg::KEY_BITS-1:0]        lookup_key_i,
  input  logic [kvt_pkg::VALUE_BITS-1:0]      new_value_i,
  input  logic [kvt_pkg::VERSION_BITS-1:0]    new_version_i,
  input  logic [kvt_pkg::VERSION_BITS-1:0]    expected_version_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          status_o,
  output logic                                found_o,
  output logic [kvt_pkg::VALUE_BITS-1:0]      read_value_o,
  output logic [kvt_pkg::VERSION_BITS-1:0]    read_version_o
);

  kvt_pkg::kvt_state_e state_q, state_d;

  // Captured command beat.
  kvt_pkg::kvt_cmd_e                  cmd_q;
  logic [kvt_pkg::KEY_BITS-1:0]       key_q;
  logic [kvt_pkg::VALUE_BITS-1:0]     value_q;
  logic [kvt_pkg::VERSION_BITS-1:0]   version_q;
  logic [kvt_pkg::VERSION_BITS-1:0]   exp_q;

  // Output register.
  logic                               out_vld_q, out_vld_d;
  kvt_pkg::kvt_status_e               out_status_q, status_d;
  logic                               out_found_q;
  logic [kvt_pkg::VALUE_BITS-1:0]     out_value_q, rval_d;
  logic [kvt_pkg::VERSION_BITS-1:0]   out_version_q, rver_d;

  logic                               in_accept;
  logic                               load;
  logic                               scan_done;
  kvt_pkg::scan_res_t                 scan_res;
  kvt_pkg::vld_upd_t                  vld_upd;
  logic                               ram_we;
  logic [kvt_pkg::IDX_W-1:0]          ram_waddr;
  logic                               ram_re;
  logic [kvt_pkg::IDX_W-1:0]          ram_raddr;
  logic [kvt_pkg::ENTRY_BITS-1:0]     ram_rdata;
  logic                               ver_match;

  assign in_stall_o = (state_q != kvt_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign ver_match  = (scan_res.hit_version == exp_q);

  // The scan owns the read port and the valid marks; all writes come from the FSM below.
  kvt_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_accept),
    .key_i     (key_q),
    .upd_i     (vld_upd),
    .rd_en_o   (ram_re),
    .rd_addr_o (ram_raddr),
    .rd_data_i (ram_rdata),
    .done_o    (scan_done),
    .res_o     (scan_res)
  );

  kvt_ram #(
    .DEPTH (kvt_pkg::ENTRIES),
    .WIDTH (kvt_pkg::ENTRY_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({key_q, value_q, version_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state, result and write-back. The key is captured at acceptance, ahead of the first
  // read and compare, so the scan sees the new key in time.
  always_comb begin
    state_d   = state_q;
    load      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = scan_res.hit_idx;
    vld_upd   = '0;
    vld_upd.idx = scan_res.hit_idx;
    status_d  = kvt_pkg::STATUS_OK;
    rval_d    = '0;
    rver_d    = '0;

    case (cmd_q)
      kvt_pkg::CMD_CREATE: begin
        if (scan_res.hit) begin
          status_d = kvt_pkg::STATUS_EXISTS;
        end else if (!scan_res.free) begin
          status_d = kvt_pkg::STATUS_FULL;
        end
      end
      kvt_pkg::CMD_READ: begin
        if (scan_res.hit) begin
          rval_d = scan_res.hit_value;
          rver_d = scan_res.hit_version;
        end
      end
      kvt_pkg::CMD_UPDATE, kvt_pkg::CMD_DELETE: begin
        if (!scan_res.hit) begin
          status_d = kvt_pkg::STATUS_MISSING;
        end else if (!ver_match) begin
          status_d = kvt_pkg::STATUS_MISMATCH;
        end
      end
      default: begin
        status_d = kvt_pkg::STATUS_OK;
      end
    endcase

    case (state_q)
      kvt_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = kvt_pkg::ST_SCAN;
        end
      end
      kvt_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = kvt_pkg::ST_RESP;
        end
      end
      kvt_pkg::ST_RESP: begin
        if (!out_vld_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = kvt_pkg::ST_IDLE;
          if (cmd_q == kvt_pkg::CMD_CREATE && !scan_res.hit && scan_res.free) begin
            ram_we      = 1'b1;
            ram_waddr   = scan_res.free_idx;
            vld_upd.set = 1'b1;
            vld_upd.idx = scan_res.free_idx;
          end
          if (cmd_q == kvt_pkg::CMD_UPDATE && scan_res.hit && ver_match) begin
            ram_we = 1'b1;
          end
          if (cmd_q == kvt_pkg::CMD_DELETE && scan_res.hit && ver_match) begin
            vld_upd.clr = 1'b1;
          end
        end
      end
      default: begin
        state_d = kvt_pkg::ST_IDLE;
      end
    endcase

    if (load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kvt_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q     <= kvt_pkg::kvt_cmd_e'(cmd_i);
      key_q     <= lookup_key_i;
      value_q   <= new_value_i;
      version_q <= new_version_i;
      exp_q     <= expected_version_i;
    end
    if (load) begin
      out_status_q  <= status_d;
      out_found_q   <= scan_res.hit;
      out_value_q   <= rval_d;
      out_version_q <= rver_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_status_q;
  assign found_o        = out_found_q;
  assign read_value_o   = out_value_q;
  assign read_version_o = out_version_q;

`ifndef ASSERT_OFF
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == kvt_pkg::ST_SCAN)
    else $error("accepted beat did not start a scan");

  a_write_only_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == kvt_pkg::ST_RESP) && load)
    else $error("entry memory written outside the response cycle");

  a_no_write_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kvt_pkg::ST_RESP && !scan_res.hit && cmd_q != kvt_pkg::CMD_CREATE)
      |-> !ram_we && !vld_upd.clr)
    else $error("table changed for a missing key");

  a_found_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_found_q && out_status_q == kvt_pkg::STATUS_FULL) &&
                  !(!out_found_q && out_status_q == kvt_pkg::STATUS_EXISTS))
    else $error("found flag disagrees with status");

  a_load_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> $past(state_q) == kvt_pkg::ST_SCAN || $past(state_q) == kvt_pkg::ST_RESP)
    else $error("result loaded without a completed scan");
`endif

endmodule
